FILE: hw/rtl/pdpc_pkg.sv
// ----------------------------------------------------------------------------
// pdpc_pkg
// Shared widths, constants, sideband type and divider tables for the PWM
// prescaler and period calculator.
// ----------------------------------------------------------------------------
package pdpc_pkg;

  localparam int FREQ_W = 27;
  localparam int DUTY_W = 14;
  localparam int CODE_W = 3;
  localparam int CNT_W  = 16;
  localparam int PROD_W = 11;
  localparam int DEN_W  = 38;
  localparam int NUM_W  = 27;
  localparam int NUM_COARSE = 8;
  localparam int NUM_FINE   = 8;

  // f*P*655350 > 10^9  <=>  f*P >= 1526
  localparam logic [PROD_W-1:0] FREQ_KNEE = 11'd1526;
  localparam logic [PROD_W-1:0] PROD_MAX  = 11'd1792;
  localparam logic [NUM_W-1:0]  TICKS     = 27'd100000000;
  // 10^8 / D > 65535  <=>  D < 1526
  localparam logic [DEN_W-1:0]  SAT_KNEE  = 38'd1526;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;
  // x/10000 = (x>>4)/625, reciprocal ceil(2^36/625)
  localparam logic [26:0] RECIP_625 = 27'd109951163;
  localparam int RECIP_SH = 36;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DUTY_HI = 2'd1;
  localparam logic [1:0] STAT_UNREACH = 2'd2;

  typedef struct packed {
    logic              unreach;
    logic              duty_hi;
    logic [CODE_W-1:0] coarse;
    logic [CODE_W-1:0] fine;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
  } side_t;

  function automatic logic [3:0] fine_val(input logic [CODE_W-1:0] j);
    logic [3:0] v;
    unique case (j)
      3'd0:    v = 4'd1;
      3'd1:    v = 4'd2;
      3'd2:    v = 4'd4;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd8;
      3'd5:    v = 4'd10;
      3'd6:    v = 4'd12;
      default: v = 4'd14;
    endcase
    return v;
  endfunction

  function automatic logic [PROD_W-1:0] prod_of(input logic [CODE_W-1:0] c,
                                                input logic [CODE_W-1:0] j);
    return PROD_W'(fine_val(j)) << c;
  endfunction

endpackage

FILE: hw/rtl/pdpc_sel.sv
// ----------------------------------------------------------------------------
// pdpc_sel
// Two stages: per-coarse-row search for the first fine code that reaches the
// needed divisor, then the smallest product across rows.
// ----------------------------------------------------------------------------
module pdpc_sel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [pdpc_pkg::FREQ_W-1:0]   in_freq,
  input  logic [pdpc_pkg::DUTY_W-1:0]   in_da,
  input  logic [pdpc_pkg::DUTY_W-1:0]   in_db,
  output logic                          out_v,
  output logic [pdpc_pkg::FREQ_W-1:0]   out_freq,
  output logic [pdpc_pkg::PROD_W-1:0]   out_prod,
  output pdpc_pkg::side_t               out_side
);
  import pdpc_pkg::*;

  logic [PROD_W-1:0]                   fc;
  logic [NUM_COARSE-1:0]               found_nxt, found1_r;
  logic [NUM_COARSE-1:0][CODE_W-1:0]   j_nxt, j1_r;
  side_t                               side_nxt, side1_r, side2_nxt, side2_r;
  logic                                v1_r, v2_r;
  logic [FREQ_W-1:0]                   f1_r, f2_r;
  logic [PROD_W-1:0]                   best_nxt, p2_r;
  logic [CODE_W-1:0]                   bc_nxt, bf_nxt;
  logic [PROD_W-1:0]                   pr;

  always_comb begin
    fc = (in_freq >= FREQ_W'(FREQ_KNEE)) ? FREQ_KNEE : in_freq[PROD_W-1:0];
    for (int c = 0; c < NUM_COARSE; c++) begin
      found_nxt[c] = 1'b0;
      j_nxt[c]     = '0;
      for (int j = NUM_FINE - 1; j >= 0; j--) begin
        if ((2*PROD_W)'(fc) * (2*PROD_W)'(prod_of(CODE_W'(c), CODE_W'(j)))
            >= (2*PROD_W)'(FREQ_KNEE)) begin
          found_nxt[c] = 1'b1;
          j_nxt[c]     = CODE_W'(j);
        end
      end
    end
    side_nxt.unreach = (in_freq == '0);
    side_nxt.duty_hi = (in_da > DUTY_FULL) || (in_db > DUTY_FULL);
    side_nxt.coarse  = '0;
    side_nxt.fine    = '0;
    side_nxt.duty_a  = in_da;
    side_nxt.duty_b  = in_db;
  end

  always_comb begin
    best_nxt = PROD_MAX;
    bc_nxt   = CODE_W'(NUM_COARSE - 1);
    bf_nxt   = CODE_W'(NUM_FINE - 1);
    pr       = '0;
    for (int c = 0; c < NUM_COARSE; c++) begin
      pr = prod_of(CODE_W'(c), j1_r[c]);
      if (found1_r[c] && pr < best_nxt) begin
        best_nxt = pr;
        bc_nxt   = CODE_W'(c);
        bf_nxt   = j1_r[c];
      end
    end
    side2_nxt        = side1_r;
    side2_nxt.coarse = bc_nxt;
    side2_nxt.fine   = bf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found1_r <= found_nxt;
      j1_r     <= j_nxt;
      f1_r     <= in_freq;
      side1_r  <= side_nxt;
      f2_r     <= f1_r;
      p2_r     <= best_nxt;
      side2_r  <= side2_nxt;
    end
  end

  assign out_v    = v2_r;
  assign out_freq = f2_r;
  assign out_prod = p2_r;
  assign out_side = side2_r;

endmodule

FILE: hw/rtl/pdpc_div.sv
// ----------------------------------------------------------------------------
// pdpc_div
// Period count: multiply prescale by frequency, then a 16-stage restoring
// divider of 10^8 by that product, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module pdpc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [pdpc_pkg::FREQ_W-1:0]   in_freq,
  input  logic [pdpc_pkg::PROD_W-1:0]   in_prod,
  input  pdpc_pkg::side_t               in_side,
  output logic                          out_v,
  output logic [pdpc_pkg::CNT_W-1:0]    out_period,
  output pdpc_pkg::side_t               out_side
);
  import pdpc_pkg::*;

  localparam int WIDE_W = NUM_W + CNT_W;

  logic              vm_r;
  logic [DEN_W-1:0]  den_r;
  side_t             sidem_r;

  logic              v_r    [CNT_W+1];
  logic              sat_r  [CNT_W+1];
  side_t             side_r [CNT_W+1];
  logic [NUM_W-1:0]  rem_r  [CNT_W+1];
  logic [NUM_W-1:0]  d_r    [CNT_W+1];
  logic [CNT_W-1:0]  q_r    [CNT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r    <= 1'b0;
      v_r[0]  <= 1'b0;
    end else if (adv) begin
      vm_r    <= in_v;
      v_r[0]  <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r     <= DEN_W'(in_prod) * DEN_W'(in_freq);
      sidem_r   <= in_side;
      side_r[0] <= sidem_r;
      sat_r[0]  <= (den_r < SAT_KNEE);
      d_r[0]    <= (den_r > DEN_W'(TICKS)) ? TICKS + NUM_W'(1) : den_r[NUM_W-1:0];
      rem_r[0]  <= TICKS;
      q_r[0]    <= '0;
    end
  end

  for (genvar s = 0; s < CNT_W; s++) begin : g_step
    localparam int SH = CNT_W - 1 - s;
    logic [WIDE_W-1:0] dsh;
    logic              ge;

    assign dsh = WIDE_W'(d_r[s]) << SH;
    assign ge  = WIDE_W'(rem_r[s]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1]  <= ge ? rem_r[s] - dsh[NUM_W-1:0] : rem_r[s];
        q_r[s+1]    <= {q_r[s][CNT_W-2:0], ge};
        d_r[s+1]    <= d_r[s];
        sat_r[s+1]  <= sat_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_v      = v_r[CNT_W];
  assign out_period = sat_r[CNT_W] ? {CNT_W{1'b1}} : q_r[CNT_W];
  assign out_side   = side_r[CNT_W];

endmodule

FILE: hw/rtl/pdpc_cmp.sv
// ----------------------------------------------------------------------------
// pdpc_cmp
// Compare values: period times duty, divide by 10000 through a reciprocal
// multiply, saturate, and form the final result beat.
// ----------------------------------------------------------------------------
module pdpc_cmp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [pdpc_pkg::CNT_W-1:0]    in_period,
  input  pdpc_pkg::side_t               in_side,
  output logic                          out_v,
  output logic [1:0]                    out_status,
  output logic [pdpc_pkg::CODE_W-1:0]   out_coarse,
  output logic [pdpc_pkg::CODE_W-1:0]   out_fine,
  output logic [pdpc_pkg::CNT_W-1:0]    out_period,
  output logic [pdpc_pkg::CNT_W-1:0]    out_cmp_a,
  output logic [pdpc_pkg::CNT_W-1:0]    out_cmp_b
);
  import pdpc_pkg::*;

  localparam int PD_W  = CNT_W + DUTY_W;
  localparam int MUL_W = PD_W - 4 + 27;
  localparam int Q_W   = MUL_W - RECIP_SH;

  logic              va_r, vb_r, vc_r;
  side_t             sa_r, sb_r;
  logic [CNT_W-1:0]  pa_r, pb_r;
  logic [PD_W-1:0]   pda_r, pdb_r;
  logic [MUL_W-1:0]  ma_r, mb_r;
  logic [Q_W-1:0]    qa, qb;
  logic [1:0]        st_r;
  logic [CODE_W-1:0] c_r, f_r;
  logic [CNT_W-1:0]  per_r, ca_r, cb_r;

  assign qa = ma_r[MUL_W-1:RECIP_SH];
  assign qb = mb_r[MUL_W-1:RECIP_SH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_v;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pda_r <= PD_W'(in_period) * PD_W'(in_side.duty_a);
      pdb_r <= PD_W'(in_period) * PD_W'(in_side.duty_b);
      pa_r  <= in_period;
      sa_r  <= in_side;
      ma_r  <= MUL_W'(pda_r[PD_W-1:4]) * MUL_W'(RECIP_625);
      mb_r  <= MUL_W'(pdb_r[PD_W-1:4]) * MUL_W'(RECIP_625);
      pb_r  <= pa_r;
      sb_r  <= sa_r;
      if (sb_r.unreach) begin
        st_r  <= STAT_UNREACH;
        c_r   <= '0;
        f_r   <= '0;
        per_r <= '0;
        ca_r  <= '0;
        cb_r  <= '0;
      end else begin
        st_r  <= sb_r.duty_hi ? STAT_DUTY_HI : STAT_OK;
        c_r   <= sb_r.coarse;
        f_r   <= sb_r.fine;
        per_r <= pb_r;
        ca_r  <= qa[Q_W-1] ? {CNT_W{1'b1}} : qa[CNT_W-1:0];
        cb_r  <= qb[Q_W-1] ? {CNT_W{1'b1}} : qb[CNT_W-1:0];
      end
    end
  end

  assign out_v      = vc_r;
  assign out_status = st_r;
  assign out_coarse = c_r;
  assign out_fine   = f_r;
  assign out_period = per_r;
  assign out_cmp_a  = ca_r;
  assign out_cmp_b  = cb_r;

endmodule

FILE: hw/rtl/pwm_divider_period_calc_unit.sv
// ----------------------------------------------------------------------------
// pwm_divider_period_calc_unit
// Picks the prescaler pair for a PWM frequency and returns the period count
// and both compare values.
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+----
//  in      | in_valid, in_ready, in_freq_hz/duty_a/b | in
//  out     | out_valid, out_ready, out_status, ...   | out
//
// One beat per cycle unless out stalls; stages: 2 select, 2 multiply/prepare,
// 16 divider bit stages, 3 compare stages. The divider's one-bit-per-stage
// chain sets the depth. Synchronous active-low reset clears the valid bits.
// A stall on out holds every stage; in_ready follows it in the same cycle.
// ----------------------------------------------------------------------------
module pwm_divider_period_calc_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdpc_pkg::FREQ_W-1:0]   in_freq_hz,
  input  logic [pdpc_pkg::DUTY_W-1:0]   in_duty_a,
  input  logic [pdpc_pkg::DUTY_W-1:0]   in_duty_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [pdpc_pkg::CODE_W-1:0]   out_coarse_div_code,
  output logic [pdpc_pkg::CODE_W-1:0]   out_fine_div_code,
  output logic [pdpc_pkg::CNT_W-1:0]    out_period_count,
  output logic [pdpc_pkg::CNT_W-1:0]    out_compare_a,
  output logic [pdpc_pkg::CNT_W-1:0]    out_compare_b
);
  import pdpc_pkg::*;

  logic              adv;
  logic              sel_v, div_v;
  logic [FREQ_W-1:0] sel_freq;
  logic [PROD_W-1:0] sel_prod;
  side_t             sel_side, div_side;
  logic [CNT_W-1:0]  div_period;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  pdpc_sel u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_freq  (in_freq_hz),
    .in_da    (in_duty_a),
    .in_db    (in_duty_b),
    .out_v    (sel_v),
    .out_freq (sel_freq),
    .out_prod (sel_prod),
    .out_side (sel_side)
  );

  pdpc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_v       (sel_v),
    .in_freq    (sel_freq),
    .in_prod    (sel_prod),
    .in_side    (sel_side),
    .out_v      (div_v),
    .out_period (div_period),
    .out_side   (div_side)
  );

  pdpc_cmp u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_v       (div_v),
    .in_period  (div_period),
    .in_side    (div_side),
    .out_v      (out_valid),
    .out_status (out_status),
    .out_coarse (out_coarse_div_code),
    .out_fine   (out_fine_div_code),
    .out_period (out_period_count),
    .out_cmp_a  (out_compare_a),
    .out_cmp_b  (out_compare_b)
  );

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_UNREACH |->
      out_period_count == '0 && out_compare_a == '0 && out_compare_b == '0 &&
      out_coarse_div_code == '0 && out_fine_div_code == '0)
    else $error("unreachable beat with non-zero fields");

  a_cmp_over_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_compare_a > out_period_count ||
                  out_compare_b > out_period_count) |->
      out_status == STAT_DUTY_HI)
    else $error("compare above period without duty flag");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed beats into the PWM prescaler and period calculator.
// Every accepted beat is scored against an integer prescaler search and
// period/compare calculation; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pdpc_pkg::*;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] da;
    logic [DUTY_W-1:0] db;
  } setting_t;

  typedef struct {
    logic [1:0]        status;
    logic [CODE_W-1:0] coarse;
    logic [CODE_W-1:0] fine;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  cmp_a;
    logic [CNT_W-1:0]  cmp_b;
  } timing_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [FREQ_W-1:0] in_freq_hz = '0;
  logic [DUTY_W-1:0] in_duty_a = '0, in_duty_b = '0;
  logic in_ready, out_valid;
  logic [1:0] out_status;
  logic [CODE_W-1:0] out_coarse_div_code, out_fine_div_code;
  logic [CNT_W-1:0] out_period_count, out_compare_a, out_compare_b;

  setting_t pending_settings[$];
  timing_t  expected_timings[$];
  int errors = 0;
  int gap = 0, stall = 0, hold_off = 0;

  pwm_divider_period_calc_unit dut (.*);

  initial forever #10 clk = ~clk;

  function automatic timing_t calc_timing(setting_t s);
    timing_t t;
    longint unsigned f, best, p, per, ca, cb;
    int bc, bf;
    longint unsigned ftab[8] = '{1, 2, 4, 6, 8, 10, 12, 14};
    f = 64'(s.freq);
    t = '{default: '0};
    if (f == 0 || f * 655350 * 1792 < 64'd1000000000) begin
      t.status = STAT_UNREACH;
      return t;
    end
    bc = 7; bf = 7; best = 128 * 14;
    for (int c = 0; c < 8; c++)
      for (int j = 0; j < 8; j++) begin
        p = ftab[j] << c;
        if (p < best && p * f * 655350 > 64'd1000000000) begin
          best = p; bc = c; bf = j;
        end
      end
    per = 64'd100000000 / (best * f);
    if (per > 65535) per = 65535;
    ca = per * 64'(s.da) / 10000; if (ca > 65535) ca = 65535;
    cb = per * 64'(s.db) / 10000; if (cb > 65535) cb = 65535;
    t.status = (s.da > DUTY_FULL || s.db > DUTY_FULL) ? STAT_DUTY_HI : STAT_OK;
    t.coarse = CODE_W'(bc); t.fine = CODE_W'(bf);
    t.period = CNT_W'(per); t.cmp_a = CNT_W'(ca); t.cmp_b = CNT_W'(cb);
    return t;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid && in_ready) void'(pending_settings.pop_front());
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 0;
      end else if (pending_settings.size() > 0) begin
        setting_t s;
        s = pending_settings[0];
        in_valid <= 1;
        in_freq_hz <= s.freq; in_duty_a <= s.da; in_duty_b <= s.db;
        gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // predictor and monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_timings.push_back(calc_timing('{in_freq_hz, in_duty_a, in_duty_b}));
      if (out_valid && out_ready) begin
        if (expected_timings.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          timing_t e;
          e = expected_timings.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++; end
          if (out_coarse_div_code !== e.coarse) begin
            $error("coarse_div_code exp %0d got %0d", e.coarse, out_coarse_div_code);
            errors++; end
          if (out_fine_div_code !== e.fine) begin
            $error("fine_div_code exp %0d got %0d", e.fine, out_fine_div_code);
            errors++; end
          if (out_period_count !== e.period) begin
            $error("period_count exp %0d got %0d", e.period, out_period_count);
            errors++; end
          if (out_compare_a !== e.cmp_a) begin
            $error("compare_a exp %0d got %0d", e.cmp_a, out_compare_a); errors++; end
          if (out_compare_b !== e.cmp_b) begin
            $error("compare_b exp %0d got %0d", e.cmp_b, out_compare_b); errors++; end
        end
      end
    end
  end

  // receiver with stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if ($urandom_range(0, 3) == 0) stall <= pick_gap();
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 5))
      0: return FREQ_W'($urandom_range(1, 2000));
      1: return FREQ_W'($urandom_range(1, 100000));
      2: return FREQ_W'($urandom_range(1, 100000000));
      3: return FREQ_W'($urandom);
      4: return FREQ_W'($urandom_range(0, 3));
      default: return FREQ_W'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] rand_duty();
    return ($urandom_range(0, 4) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(0, 10000));
  endfunction

  initial begin
    logic [FREQ_W-1:0] fd[12] = '{0, 1, 2, 100, 1525, 1526, 1527, 20000,
                                  100000000, 27'h7FFFFFF, 763, 50};
    logic [DUTY_W-1:0] dd[6] = '{0, 10000, 10001, 14'h3FFF, 5000, 1};
    int cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    foreach (fd[i])
      pending_settings.push_back('{fd[i], dd[i % 6], dd[(i + 3) % 6]});
    pending_settings.push_back('{FREQ_W'(1000), 14'h3FFF, 14'h3FFF});
    for (int i = 0; i < 1500; i++)
      pending_settings.push_back('{rand_freq(), rand_duty(), rand_duty()});
    cnt = 0;
    while (cnt < 400) begin
      @(posedge clk);
      cnt++;
    end
    hold_off = 150;
    while (pending_settings.size() > 0) @(posedge clk);
    while (expected_timings.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_timings.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
